### rtl/gbn_pkg.sv
`timescale 1ns / 1ps

package gbn_pkg;

  // Fixed field widths
  localparam int unsigned SegW = 16;
  localparam int unsigned WinW = 5;
  localparam int unsigned ThrW = 3;

  // Largest window the sender honors; wider settings clamp to it
  localparam int unsigned MaxWindow = 16;
  // Width of the sequence space; sequence numbers wrap at 2^SeqWidth
  localparam int unsigned SeqWidth  = 16;

  // Effective window holds up to MaxWindow (at most 127)
  localparam int unsigned WinEffW = 7;
  localparam logic [WinEffW-1:0] MaxWin = WinEffW'(MaxWindow);
  localparam logic [SegW-1:0]    SeqMask = SegW'((64'd1 << SeqWidth) - 64'd1);

  // Input commands
  typedef enum logic [1:0] {
    CmdStart = 2'd0,
    CmdAck   = 2'd1,
    CmdTick  = 2'd2
  } cmd_e;

  // Why a send order was issued
  typedef enum logic [1:0] {
    RsnNone    = 2'd0,
    RsnNew     = 2'd1,
    RsnTimeout = 2'd2,
    RsnFast    = 2'd3
  } reason_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgWindow  = 2'd0,
    CfgTimeout = 2'd1,
    CfgDupThr  = 2'd2
  } cfg_idx_e;

  // Front-end sequencer states
  typedef enum logic [1:0] {
    FeIdle,
    FeEval,
    FeFill
  } fe_state_e;

  typedef struct packed {
    logic [WinW-1:0] win_len;
    logic [SegW-1:0] timeout_ticks;
    logic [ThrW-1:0] dup_threshold;
  } cfg_t;

  // One job for the back end: a run of send orders, or a done report
  typedef struct packed {
    logic            done;
    reason_e         reason;
    logic [SegW-1:0] first;
    logic [SegW-1:0] stop;
    logic [SegW-1:0] seq;
  } job_t;

endpackage

### rtl/go_back_n_sender_fast_retransmit.sv
`timescale 1ns / 1ps

// Go-Back-N sender control with fast retransmit. An input beat (start, ACK
// or tick) that leads to a window fill or a done report passes through the
// front-end steps capture, evaluate and window fill before the next beat is
// taken; a beat that the front end drops (start while active, ACK or tick
// while idle, a tick short of the timeout, an unused command) skips the fill.
// The front end stalls further only when the two-entry job queue is full. The
// back end then emits one result beat per cycle while out_ready_i is high, so
// an item that orders n sends (n at most the window, 16) holds the output for
// n result beats while the front end goes on with later items.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while the
// block is idle; index 0 is the window size, 1 the timeout in ticks, 2 the
// duplicate ACK threshold.
module go_back_n_sender_fast_retransmit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [gbn_pkg::SegW-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               cmd_i,
  input  logic [gbn_pkg::SegW-1:0] segment_count_i,
  input  logic [gbn_pkg::SegW-1:0] ack_seq_i,
  input  logic                     ack_ok_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     send_valid_o,
  output logic [gbn_pkg::SegW-1:0] send_index_o,
  output logic [gbn_pkg::SegW-1:0] send_seq_o,
  output logic [1:0]               send_reason_o,
  output logic                     done_res_o,
  output logic                     last_o
);

  gbn_pkg::cfg_t cfg_q;
  logic          push;
  gbn_pkg::job_t push_job;
  logic          full;
  logic          pop;
  gbn_pkg::job_t pop_job;
  logic          empty;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_len       <= gbn_pkg::WinW'(5);
      cfg_q.timeout_ticks <= gbn_pkg::SegW'(1000);
      cfg_q.dup_threshold <= gbn_pkg::ThrW'(3);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gbn_pkg::CfgWindow:  cfg_q.win_len       <= cfg_data_i[gbn_pkg::WinW-1:0];
        gbn_pkg::CfgTimeout: cfg_q.timeout_ticks <= cfg_data_i;
        gbn_pkg::CfgDupThr:  cfg_q.dup_threshold <= cfg_data_i[gbn_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  gbn_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .segment_count_i (segment_count_i),
    .ack_seq_i       (ack_seq_i),
    .ack_ok_i        (ack_ok_i),
    .push_o          (push),
    .push_job_o      (push_job),
    .full_i          (full)
  );

  gbn_jobq u_jobq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .empty_o    (empty)
  );

  gbn_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .job_i         (pop_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .send_valid_o  (send_valid_o),
    .send_index_o  (send_index_o),
    .send_seq_o    (send_seq_o),
    .send_reason_o (send_reason_o),
    .done_res_o    (done_res_o),
    .last_o        (last_o)
  );

endmodule

### rtl/gbn_front.sv
`timescale 1ns / 1ps

module gbn_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gbn_pkg::cfg_t                    cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       cmd_i,
  input  logic [gbn_pkg::SegW-1:0]         segment_count_i,
  input  logic [gbn_pkg::SegW-1:0]         ack_seq_i,
  input  logic                             ack_ok_i,
  output logic                             push_o,
  output gbn_pkg::job_t                    push_job_o,
  input  logic                             full_i
);

  gbn_pkg::fe_state_e state_q, state_d;

  // Latched item
  logic [1:0]                cmd_q;
  logic [gbn_pkg::SegW-1:0]  count_q;
  logic [gbn_pkg::SegW-1:0]  ack_q;
  logic                      ok_q;

  // Protocol state
  logic                      active_q, active_d;
  logic [gbn_pkg::SegW-1:0]  base_q, base_d;
  logic [gbn_pkg::SegW-1:0]  next_q, next_d;
  logic [gbn_pkg::SegW-1:0]  total_q, total_d;
  logic [gbn_pkg::SegW-1:0]  start_q, start_d;
  logic [gbn_pkg::SegW-1:0]  last_ack_q, last_ack_d;
  logic [gbn_pkg::ThrW-1:0]  dup_q, dup_d;
  logic [gbn_pkg::SegW-1:0]  fmark_q, fmark_d;
  logic [gbn_pkg::SegW-1:0]  timer_q, timer_d;
  logic                      finish_q, finish_d;
  gbn_pkg::reason_e          reason_q, reason_d;

  logic                      accept;
  logic                      go_fill;
  logic                      fill_done;
  logic                      push;

  logic [gbn_pkg::WinEffW-1:0] win_eff;
  logic [gbn_pkg::ThrW-1:0]    thr_eff;
  logic [gbn_pkg::SegW:0]      diff;
  logic                        in_range;
  logic [gbn_pkg::ThrW-1:0]    dup_inc;
  logic [gbn_pkg::SegW-1:0]    timer_inc;
  logic [gbn_pkg::SegW-1:0]    nx;
  logic [gbn_pkg::SegW:0]      limit;
  logic [gbn_pkg::SegW:0]      stop;
  logic                        has_send;

  assign in_ready_o = (state_q == gbn_pkg::FeIdle);
  assign accept     = in_valid_i && in_ready_o;

  // Clamp window and threshold to their working ranges
  always_comb begin
    if (cfg_i.win_len == '0) begin
      win_eff = gbn_pkg::WinEffW'(1);
    end else if (gbn_pkg::WinEffW'(cfg_i.win_len) > gbn_pkg::MaxWin) begin
      win_eff = gbn_pkg::MaxWin;
    end else begin
      win_eff = gbn_pkg::WinEffW'(cfg_i.win_len);
    end
    thr_eff = (cfg_i.dup_threshold == '0) ? gbn_pkg::ThrW'(1) : cfg_i.dup_threshold;
  end

  // ACK index relative to the start sequence, signed
  assign diff     = {1'b0, ack_q} - {1'b0, start_q};
  assign in_range = !diff[gbn_pkg::SegW] && (diff[gbn_pkg::SegW-1:0] >= base_q)
                    && (diff[gbn_pkg::SegW-1:0] < total_q);
  assign dup_inc   = dup_q + gbn_pkg::ThrW'(1);
  assign timer_inc = (timer_q == '1) ? timer_q : timer_q + gbn_pkg::SegW'(1);

  // Window range: send from max(next, base) up to min(total, base + window)
  assign nx       = (next_q < base_q) ? base_q : next_q;
  assign limit    = {1'b0, base_q} + (gbn_pkg::SegW + 1)'(win_eff);
  assign stop     = ({1'b0, total_q} < limit) ? {1'b0, total_q} : limit;
  assign has_send = ({1'b0, nx} < stop);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gbn_pkg::FeIdle: if (accept) state_d = gbn_pkg::FeEval;
      gbn_pkg::FeEval: state_d = go_fill ? gbn_pkg::FeFill : gbn_pkg::FeIdle;
      gbn_pkg::FeFill: if (fill_done) state_d = gbn_pkg::FeIdle;
      default:         state_d = gbn_pkg::FeIdle;
    endcase
  end

  // Evaluate the item, then fill the window or report done
  always_comb begin
    active_d   = active_q;
    base_d     = base_q;
    next_d     = next_q;
    total_d    = total_q;
    start_d    = start_q;
    last_ack_d = last_ack_q;
    dup_d      = dup_q;
    fmark_d    = fmark_q;
    timer_d    = timer_q;
    finish_d   = finish_q;
    reason_d   = reason_q;
    go_fill    = 1'b0;
    push       = 1'b0;
    push_job_o = '0;

    unique case (state_q)
      gbn_pkg::FeEval: begin
        unique case (cmd_q)
          gbn_pkg::CmdStart: begin
            if (!active_q) begin
              active_d   = 1'b1;
              total_d    = count_q;
              base_d     = '0;
              next_d     = '0;
              last_ack_d = '0;
              dup_d      = '0;
              fmark_d    = '0;
              timer_d    = '0;
              finish_d   = 1'b1;
              reason_d   = gbn_pkg::RsnNew;
              go_fill    = 1'b1;
            end
          end
          gbn_pkg::CmdAck: begin
            if (active_q) begin
              timer_d  = '0;
              finish_d = 1'b1;
              reason_d = gbn_pkg::RsnNew;
              go_fill  = 1'b1;
              if (ok_q) begin
                if (ack_q == last_ack_q) begin
                  // Duplicate: count it unless it already caused a fast resend
                  if (fmark_q != ack_q) begin
                    if (dup_inc >= thr_eff) begin
                      next_d   = base_q;
                      fmark_d  = ack_q;
                      dup_d    = '0;
                      reason_d = gbn_pkg::RsnFast;
                    end else begin
                      dup_d = dup_inc;
                    end
                  end
                end else if (ack_q > last_ack_q) begin
                  // Higher ACK: advance base when it lies inside the transfer
                  last_ack_d = ack_q;
                  dup_d      = '0;
                  fmark_d    = '0;
                  if (in_range) begin
                    base_d = diff[gbn_pkg::SegW-1:0] + gbn_pkg::SegW'(1);
                  end
                end
              end
            end
          end
          gbn_pkg::CmdTick: begin
            if (active_q) begin
              if (timer_inc >= cfg_i.timeout_ticks) begin
                timer_d  = '0;
                next_d   = base_q;
                finish_d = 1'b0;
                reason_d = gbn_pkg::RsnTimeout;
                go_fill  = 1'b1;
              end else begin
                timer_d = timer_inc;
              end
            end
          end
          default: ;
        endcase
      end
      gbn_pkg::FeFill: begin
        if (finish_q && (base_q >= total_q)) begin
          push              = 1'b1;
          push_job_o.done   = 1'b1;
          push_job_o.reason = gbn_pkg::RsnNone;
          if (!full_i) begin
            active_d = 1'b0;
            start_d  = (start_q + total_q) & gbn_pkg::SeqMask;
          end
        end else if (has_send) begin
          push              = 1'b1;
          push_job_o.reason = reason_q;
          push_job_o.first  = nx;
          push_job_o.stop   = stop[gbn_pkg::SegW-1:0];
          push_job_o.seq    = (start_q + nx) & gbn_pkg::SeqMask;
          if (!full_i) next_d = stop[gbn_pkg::SegW-1:0];
        end else begin
          next_d = nx;
        end
      end
      default: ;
    endcase
  end

  assign fill_done = !push || !full_i;
  assign push_o    = push;

  // Hold the accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      count_q <= segment_count_i;
      ack_q   <= ack_seq_i;
      ok_q    <= ack_ok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= gbn_pkg::FeIdle;
      active_q   <= 1'b0;
      base_q     <= '0;
      next_q     <= '0;
      total_q    <= '0;
      start_q    <= gbn_pkg::SegW'(1);
      last_ack_q <= '0;
      dup_q      <= '0;
      fmark_q    <= '0;
      timer_q    <= '0;
      finish_q   <= 1'b0;
      reason_q   <= gbn_pkg::RsnNone;
    end else begin
      state_q    <= state_d;
      active_q   <= active_d;
      base_q     <= base_d;
      next_q     <= next_d;
      total_q    <= total_d;
      start_q    <= start_d;
      last_ack_q <= last_ack_d;
      dup_q      <= dup_d;
      fmark_q    <= fmark_d;
      timer_q    <= timer_d;
      finish_q   <= finish_d;
      reason_q   <= reason_d;
    end
  end

endmodule

### rtl/gbn_jobq.sv
`timescale 1ns / 1ps

module gbn_jobq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gbn_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output gbn_pkg::job_t pop_job_o,
  output logic          empty_o
);

  gbn_pkg::job_t mem_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          do_push;
  logic          do_pop;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_job_o = mem_q[rd_ptr_q];

  // Store incoming jobs
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_job_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job queue popped while empty");
`endif

endmodule

### rtl/gbn_back.sv
`timescale 1ns / 1ps

module gbn_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     empty_i,
  input  gbn_pkg::job_t            job_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     send_valid_o,
  output logic [gbn_pkg::SegW-1:0] send_index_o,
  output logic [gbn_pkg::SegW-1:0] send_seq_o,
  output logic [1:0]               send_reason_o,
  output logic                     done_res_o,
  output logic                     last_o
);

  logic                     busy_q;
  logic                     done_q;
  gbn_pkg::reason_e         reason_q;
  logic [gbn_pkg::SegW-1:0] idx_q;
  logic [gbn_pkg::SegW-1:0] stop_q;
  logic [gbn_pkg::SegW-1:0] seq_q;

  logic is_last;
  logic take;
  logic free;

  assign is_last = done_q || (({1'b0, idx_q} + 17'd1) == {1'b0, stop_q});
  assign take    = busy_q && out_ready_i;
  assign free    = !busy_q || (take && is_last);
  assign pop_o   = free && !empty_i;

  // Drive the result beat from the current job
  assign out_valid_o   = busy_q;
  assign send_valid_o  = !done_q;
  assign send_index_o  = done_q ? '0 : idx_q;
  assign send_seq_o    = done_q ? '0 : seq_q;
  assign send_reason_o = done_q ? 2'(gbn_pkg::RsnNone) : reason_q;
  assign done_res_o    = done_q;
  assign last_o        = is_last;

  // Load a new job, or step through the current run
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      done_q   <= job_i.done;
      reason_q <= job_i.reason;
      idx_q    <= job_i.first;
      stop_q   <= job_i.stop;
      seq_q    <= job_i.seq;
    end else if (take && !is_last) begin
      idx_q <= idx_q + gbn_pkg::SegW'(1);
      seq_q <= (seq_q + gbn_pkg::SegW'(1)) & gbn_pkg::SeqMask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
    end else if (take && is_last) begin
      busy_q <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> last_o)
    else $error("done beat not marked last");
  a_send_has_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_valid_o |-> send_reason_o != 2'(gbn_pkg::RsnNone))
    else $error("send beat without reason");
  a_run_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !done_q |-> idx_q < stop_q)
    else $error("send index ran past end of run");
`endif

endmodule

### tb/sv/go_back_n_sender_fast_retransmit_test.sv
`timescale 1ns / 1ps

module go_back_n_sender_fast_retransmit_test;

  localparam int unsigned SegW      = gbn_pkg::SegW;
  localparam int unsigned WinW      = gbn_pkg::WinW;
  localparam int unsigned ThrW      = gbn_pkg::ThrW;
  localparam int unsigned MaxWindow = gbn_pkg::MaxWindow;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned PhaseItems   = 50;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned BusyPct      = 26;
  // Command code the block must ignore
  localparam logic [1:0]  CmdUnused    = 2'd3;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [SegW-1:0] count;
    logic [SegW-1:0] ack;
    logic            ok;
  } arq_item_t;

  typedef struct packed {
    logic             send_valid;
    logic [SegW-1:0]  index;
    logic [SegW-1:0]  seq;
    gbn_pkg::reason_e reason;
    logic             done;
    logic             last;
  } send_order_t;

  logic            clk_i           = 1'b0;
  logic            rst_ni          = 1'b0;
  logic            cfg_we_i        = 1'b0;
  logic [1:0]      cfg_idx_i       = 2'd0;
  logic [SegW-1:0] cfg_data_i      = '0;
  logic            in_valid_i      = 1'b0;
  logic            in_ready_o;
  logic [1:0]      cmd_i           = 2'd0;
  logic [SegW-1:0] segment_count_i = '0;
  logic [SegW-1:0] ack_seq_i       = '0;
  logic            ack_ok_i        = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i     = 1'b0;
  logic            send_valid_o;
  logic [SegW-1:0] send_index_o;
  logic [SegW-1:0] send_seq_o;
  logic [1:0]      send_reason_o;
  logic            done_res_o;
  logic            last_o;

  // Pending input beats, the beat on the bus, and the orders still owed
  arq_item_t   cmd_backlog[$];
  arq_item_t   on_bus;
  send_order_t orders_due[$];
  send_order_t new_orders[$];

  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned items_queued  = 0;
  int unsigned drv_idle_pct  = BusyPct;
  int unsigned mon_stall_pct = BusyPct;

  // Shadow of the sender: configuration and transfer state
  logic [WinW-1:0] win_cfg       = WinW'(5);
  logic [SegW-1:0] timeout_cfg   = SegW'(1000);
  logic [ThrW-1:0] dupthr_cfg    = ThrW'(3);
  logic            snd_active    = 1'b0;
  logic [SegW-1:0] snd_base      = '0;
  logic [SegW-1:0] snd_next      = '0;
  logic [SegW-1:0] snd_total     = '0;
  logic [SegW-1:0] snd_start_seq = SegW'(1);
  logic [SegW-1:0] snd_last_ack  = '0;
  logic [ThrW-1:0] snd_dups      = '0;
  logic [SegW-1:0] snd_fast_mark = '0;
  logic [SegW-1:0] snd_idle      = '0;

  go_back_n_sender_fast_retransmit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .segment_count_i(segment_count_i),
    .ack_seq_i      (ack_seq_i),
    .ack_ok_i       (ack_ok_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .send_valid_o   (send_valid_o),
    .send_index_o   (send_index_o),
    .send_seq_o     (send_seq_o),
    .send_reason_o  (send_reason_o),
    .done_res_o     (done_res_o),
    .last_o         (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Issue send orders from next up to the window edge
  function automatic void fill_orders(gbn_pkg::reason_e reason);
    int unsigned win;
    int unsigned edge_idx;
    win = (win_cfg == 0) ? 1 : ((win_cfg > MaxWindow) ? MaxWindow : int'(win_cfg));
    if (snd_next < snd_base) snd_next = snd_base;
    edge_idx = snd_base + win;
    while (snd_next < snd_total && snd_next < edge_idx && new_orders.size() < MaxWindow) begin
      new_orders.push_back('{1'b1, snd_next, SegW'(snd_start_seq + snd_next), reason, 1'b0,
                             1'b0});
      snd_next = SegW'(snd_next + 1);
    end
  endfunction

  // Report done once the base covers the transfer, else refill the window
  function automatic void finish_or_fill(gbn_pkg::reason_e reason);
    if (snd_base >= snd_total) begin
      snd_active    = 1'b0;
      snd_start_seq = SegW'(snd_start_seq + snd_total);
      new_orders.push_back('{1'b0, '0, '0, gbn_pkg::RsnNone, 1'b1, 1'b0});
    end else begin
      fill_orders(reason);
    end
  endfunction

  // Advance the shadow state by one accepted beat and queue the orders it owes
  function automatic void predict_orders(arq_item_t it);
    gbn_pkg::reason_e reason;
    int               offset;
    logic [ThrW-1:0]  thr;
    reason = gbn_pkg::RsnNew;
    new_orders.delete();
    case (it.cmd)
      gbn_pkg::CmdStart: begin
        if (!snd_active) begin
          snd_active    = 1'b1;
          snd_total     = it.count;
          snd_base      = '0;
          snd_next      = '0;
          snd_last_ack  = '0;
          snd_dups      = '0;
          snd_fast_mark = '0;
          snd_idle      = '0;
          finish_or_fill(gbn_pkg::RsnNew);
        end
      end
      gbn_pkg::CmdAck: begin
        if (snd_active) begin
          snd_idle = '0;
          if (it.ok) begin
            if (it.ack == snd_last_ack) begin
              // Count duplicates unless this ACK already caused a fast resend
              if (snd_fast_mark != it.ack) begin
                thr      = (dupthr_cfg == 0) ? ThrW'(1) : dupthr_cfg;
                snd_dups = ThrW'(snd_dups + 1);
                if (snd_dups >= thr) begin
                  snd_next      = snd_base;
                  snd_fast_mark = it.ack;
                  snd_dups      = '0;
                  reason        = gbn_pkg::RsnFast;
                end
              end
            end else if (it.ack > snd_last_ack) begin
              offset        = int'(it.ack) - int'(snd_start_seq);
              snd_last_ack  = it.ack;
              snd_dups      = '0;
              snd_fast_mark = '0;
              if (offset >= int'(snd_base) && offset < int'(snd_total))
                snd_base = SegW'(offset + 1);
            end
          end
          finish_or_fill(reason);
        end
      end
      gbn_pkg::CmdTick: begin
        if (snd_active) begin
          if (snd_idle != '1) snd_idle = SegW'(snd_idle + 1);
          if (snd_idle >= timeout_cfg) begin
            snd_idle = '0;
            snd_next = snd_base;
            fill_orders(gbn_pkg::RsnTimeout);
          end
        end
      end
      default: ;
    endcase
    if (new_orders.size() > 0) new_orders[new_orders.size() - 1].last = 1'b1;
    foreach (new_orders[k]) orders_due.push_back(new_orders[k]);
  endfunction

  // Input driver: predict on each accepted beat, then present the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      cmd_i           <= 2'd0;
      segment_count_i <= '0;
      ack_seq_i       <= '0;
      ack_ok_i        <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) predict_orders(on_bus);
      if (!in_valid_i || in_ready_o) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99, 0) >= drv_idle_pct) begin
          on_bus = cmd_backlog.pop_front();
          in_valid_i      <= 1'b1;
          cmd_i           <= on_bus.cmd;
          segment_count_i <= on_bus.count;
          ack_seq_i       <= on_bus.ack;
          ack_ok_i        <= on_bus.ok;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
  endtask

  // Output monitor: check each result beat against the oldest owed order
  always @(posedge clk_i or negedge rst_ni) begin
    send_order_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (orders_due.size() == 0) begin
          flag_mismatch("unexpected result index", 0, send_index_o);
        end else begin
          want = orders_due.pop_front();
          if (send_valid_o !== want.send_valid)
            flag_mismatch("send_valid", want.send_valid, send_valid_o);
          if (send_index_o !== want.index) flag_mismatch("send_index", want.index, send_index_o);
          if (send_seq_o !== want.seq) flag_mismatch("send_seq", want.seq, send_seq_o);
          if (send_reason_o !== want.reason)
            flag_mismatch("send_reason", want.reason, send_reason_o);
          if (done_res_o !== want.done) flag_mismatch("done_res", want.done, done_res_o);
          if (last_o !== want.last) flag_mismatch("last", want.last, last_o);
        end
      end
      out_ready_i <= ($urandom_range(99, 0) >= mon_stall_pct);
    end
  end

  task automatic push_item(logic [1:0] cmd, logic [SegW-1:0] count, logic [SegW-1:0] ack,
                           logic ok);
    cmd_backlog.push_back('{cmd, count, ack, ok});
    items_queued++;
  endtask

  // Hold until every queued beat has been accepted
  task automatic drain_inputs();
    while (cmd_backlog.size() != 0 || in_valid_i) @(negedge clk_i);
  endtask

  // Hold until the block is idle: inputs taken, orders out, front end empty
  task automatic settle();
    drain_inputs();
    while (orders_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(gbn_pkg::cfg_idx_e idx, logic [SegW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      gbn_pkg::CfgWindow:  win_cfg     = value[WinW-1:0];
      gbn_pkg::CfgTimeout: timeout_cfg = value;
      gbn_pkg::CfgDupThr:  dupthr_cfg  = value[ThrW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned win, int unsigned tmo, int unsigned thr);
    settle();
    write_reg(gbn_pkg::CfgWindow, SegW'(win));
    write_reg(gbn_pkg::CfgTimeout, SegW'(tmo));
    write_reg(gbn_pkg::CfgDupThr, SegW'(thr));
  endtask

  // One well-formed transfer with random acks, duplicates, ticks and noise
  task automatic run_transfer();
    logic [SegW-1:0] s;
    logic [SegW-1:0] dup_ack;
    int unsigned     cnt;
    int unsigned     pick;
    int              acked;
    drain_inputs();
    s    = snd_start_seq;
    pick = $urandom_range(99, 0);
    if (pick < 10) cnt = 0;
    else if (pick < 75) cnt = $urandom_range(12, 1);
    else if (pick < 95) cnt = $urandom_range(48, 13);
    else cnt = $urandom_range(1500, 100);
    // Keep the last ACK inside the unsigned sequence space
    if (cnt > 65536 - s) cnt = 65536 - s;
    if (s == 0 && cnt == 1) cnt = 2;
    push_item(gbn_pkg::CmdStart, SegW'(cnt), SegW'($urandom), 1'($urandom));
    if (cnt != 0) begin
      acked = -1;
      repeat ($urandom_range(8, 1)) begin
        pick    = $urandom_range(99, 0);
        dup_ack = (acked < 0) ? '0 : SegW'(s + acked);
        if (pick < 40) begin
          if (cnt >= 2) begin
            acked = acked + int'($urandom_range(5, 1));
            if (acked > int'(cnt) - 2) acked = int'(cnt) - 2;
            push_item(gbn_pkg::CmdAck, SegW'($urandom), SegW'(s + acked), 1'b1);
          end
        end else if (pick < 55) begin
          repeat ($urandom_range(8, 1))
            push_item(gbn_pkg::CmdAck, SegW'($urandom), dup_ack, 1'b1);
        end else if (pick < 65) begin
          push_item(gbn_pkg::CmdAck, SegW'($urandom), SegW'($urandom), 1'b0);
        end else if (pick < 85) begin
          repeat ($urandom_range(6, 1))
            push_item(gbn_pkg::CmdTick, SegW'($urandom), SegW'($urandom), 1'($urandom));
        end else if (pick < 92) begin
          push_item(gbn_pkg::CmdStart, SegW'($urandom), SegW'($urandom), 1'($urandom));
        end else if (pick < 96) begin
          if (s != 0)
            push_item(gbn_pkg::CmdAck, SegW'($urandom), SegW'($urandom_range(s - 1, 0)), 1'b1);
        end else begin
          push_item(CmdUnused, SegW'($urandom), SegW'($urandom), 1'($urandom));
        end
      end
      // Close the transfer with the ACK of its last segment
      push_item(gbn_pkg::CmdAck, SegW'($urandom), SegW'(s + cnt - 1), 1'b1);
    end
    // Stray beats while idle
    if ($urandom_range(99, 0) < 20)
      push_item(2'($urandom_range(3, 1)), SegW'($urandom), SegW'($urandom), 1'($urandom));
  endtask

  task automatic random_phase();
    int unsigned target;
    target = items_queued + PhaseItems;
    while (items_queued < target) run_transfer();
  endtask

  initial begin
    logic [SegW-1:0] s;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: idle beats, empty transfer, full-range transfer
    push_item(gbn_pkg::CmdAck, 16'd0, 16'd5, 1'b1);
    push_item(gbn_pkg::CmdTick, 16'd0, 16'd0, 1'b0);
    push_item(CmdUnused, 16'hFFFF, 16'hFFFF, 1'b1);
    push_item(gbn_pkg::CmdStart, 16'd0, 16'd0, 1'b0);
    push_item(gbn_pkg::CmdStart, 16'hFFFF, 16'd0, 1'b0);
    push_item(gbn_pkg::CmdStart, 16'd3, 16'd0, 1'b0);
    push_item(gbn_pkg::CmdAck, 16'd0, 16'd0, 1'b1);
    push_item(gbn_pkg::CmdAck, 16'd0, 16'd3, 1'b0);
    push_item(gbn_pkg::CmdAck, 16'd0, 16'd2, 1'b1);
    repeat (4) push_item(gbn_pkg::CmdAck, 16'd0, 16'd2, 1'b1);
    push_item(gbn_pkg::CmdAck, 16'd0, 16'd20, 1'b1);
    push_item(gbn_pkg::CmdAck, 16'd0, 16'hFFFF, 1'b1);
    // Sequence numbers wrapped to zero: ACK of zero is a marked duplicate
    push_item(gbn_pkg::CmdStart, 16'd3, 16'd0, 1'b0);
    push_item(gbn_pkg::CmdAck, 16'd0, 16'd0, 1'b1);
    push_item(gbn_pkg::CmdAck, 16'd0, 16'd2, 1'b1);

    // Out-of-range settings clamp; zero timeout fires on every tick
    set_config(0, 0, 0);
    s = snd_start_seq;
    push_item(gbn_pkg::CmdStart, 16'd2, 16'd0, 1'b0);
    push_item(gbn_pkg::CmdTick, 16'd0, 16'd0, 1'b0);
    push_item(gbn_pkg::CmdAck, 16'd0, s, 1'b1);
    push_item(gbn_pkg::CmdAck, 16'd0, s, 1'b1);
    push_item(gbn_pkg::CmdTick, 16'd0, 16'd0, 1'b0);
    push_item(gbn_pkg::CmdAck, 16'd0, SegW'(s + 1), 1'b1);

    // Widest window: a full burst of sends, ACK below the transfer, timeout
    set_config(31, 2, 7);
    s = snd_start_seq;
    push_item(gbn_pkg::CmdStart, 16'd40, 16'd0, 1'b0);
    push_item(gbn_pkg::CmdAck, 16'd0, SegW'(s - 1), 1'b1);
    repeat (2) push_item(gbn_pkg::CmdTick, 16'd0, 16'd0, 1'b0);
    push_item(gbn_pkg::CmdAck, 16'd0, SegW'(s + 39), 1'b1);

    set_config(4, 3, 2);
    random_phase();

    // Long stretch with no idling on either side
    set_config(16, 1, 1);
    drv_idle_pct  = 0;
    mon_stall_pct = 0;
    random_phase();
    drv_idle_pct  = BusyPct;
    mon_stall_pct = BusyPct;

    set_config(1, 65535, 7);
    random_phase();

    set_config($urandom_range(MaxWindow, 1), $urandom_range(6, 1), $urandom_range(7, 1));
    random_phase();

    // ACK past the end of the transfer stalls it for good, so run it last
    drain_inputs();
    s = snd_start_seq;
    push_item(gbn_pkg::CmdStart, 16'd6, 16'd0, 1'b0);
    push_item(gbn_pkg::CmdAck, 16'd0, SegW'(s + 6), 1'b1);
    push_item(gbn_pkg::CmdAck, 16'd0, SegW'(s + 2), 1'b1);
    repeat (8) push_item(gbn_pkg::CmdTick, 16'd0, 16'd0, 1'b0);

    settle();
    if (fail_count == 0 && orders_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
